// ===== rtl/core/rbox_pkg.sv =====
// ----------------------------------------------------------------------------
// Ray box package
// Widths, constants and shared types of the ray versus unit box slab unit.
// ----------------------------------------------------------------------------
package rbox_pkg;

   localparam int DATA_W = 32;
   localparam int THR_W  = 16;

   localparam logic [THR_W-1:0]  THR_RESET = 16'd7;
   localparam logic [DATA_W-1:0] SAT_HI    = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_LO    = 32'h8000_0000;

   // Divider: one setup stage and one stage per quotient bit.
   localparam int DIV_LAT  = DATA_W + 1;
   // Axis: front stage, divider, saturate and order stage.
   localparam int AXIS_LAT = DIV_LAT + 2;
   // Whole pipeline up to the reduced near and far distances.
   localparam int PIPE_LAT = AXIS_LAT + 1;

   // Limits that one axis puts on the ray; enter and leave are signed.
   typedef struct packed {
      logic              miss;
      logic [DATA_W-1:0] enter;
      logic [DATA_W-1:0] leave;
   } slab_type;

endpackage

// ===== rtl/core/rbox_if.sv =====
// ----------------------------------------------------------------------------
// Ray box channels
// Valid and ready channels for rays in and intersection results out.
// ----------------------------------------------------------------------------
interface rbox_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] direction_x;
   logic signed [31:0] direction_y;
   logic signed [31:0] direction_z;

   modport source (
      output valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
      input  ready
   );
   modport sink (
      input  valid, origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
      output ready
   );
endinterface

interface rbox_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic signed [31:0] t_near;
   logic signed [31:0] t_far;

   modport source (
      output valid, hit, t_near, t_far,
      input  ready
   );
   modport sink (
      input  valid, hit, t_near, t_far,
      output ready
   );
endinterface

// ===== rtl/core/rbox_div.sv =====
// ----------------------------------------------------------------------------
// Ray box divider
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rbox_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic [rbox_pkg::DATA_W-1:0] num_mag,
   input  logic [rbox_pkg::DATA_W-1:0] den,
   output logic [rbox_pkg::DATA_W-1:0] quo,
   output logic                       ovf
);

   localparam int QW = rbox_pkg::DATA_W;

   // The dividend is num_mag shifted left by the fraction bits. Its upper word
   // seeds the remainder; if that word already reaches the divisor, the
   // quotient needs more than QW bits and is flagged as overflow.
   logic [QW-1:0] hi_word;
   logic [QW-1:0] lo_word;

   assign hi_word = QW'(num_mag[QW-1:QW-FRACTION_BITS]);
   assign lo_word = {num_mag[QW-1-FRACTION_BITS:0], {FRACTION_BITS{1'b0}}};

   logic [QW-1:0] rem_ff [0:QW];
   logic [QW-1:0] low_ff [0:QW];
   logic [QW-1:0] quo_ff [0:QW];
   logic [QW-1:0] den_ff [0:QW];
   logic          ovf_ff [0:QW];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi_word;
         low_ff[0] <= lo_word;
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= (hi_word >= den);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [QW:0] diff;

      assign diff = {rem_ff[k], low_ff[k][QW-1]} - {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!diff[QW]) begin
               rem_ff[k+1] <= diff[QW-1:0];
               quo_ff[k+1] <= {quo_ff[k][QW-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= {rem_ff[k][QW-2:0], low_ff[k][QW-1]};
               quo_ff[k+1] <= {quo_ff[k][QW-2:0], 1'b0};
            end
            low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo = quo_ff[QW];
   assign ovf = ovf_ff[QW];

endmodule

// ===== rtl/core/rbox_axis.sv =====
// ----------------------------------------------------------------------------
// Ray box axis slab
// Entry and exit distances of one axis against the planes at -1 and +1.
// ----------------------------------------------------------------------------
module rbox_axis #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic signed [rbox_pkg::DATA_W-1:0] origin,
   input  logic signed [rbox_pkg::DATA_W-1:0] direction,
   input  logic [rbox_pkg::THR_W-1:0]      threshold,
   output rbox_pkg::slab_type              slab
);

   localparam int W = rbox_pkg::DATA_W;
   localparam logic signed [W:0] ONE = (W+1)'(1) << FRACTION_BITS;

   typedef struct packed {
      logic neg_lo;
      logic neg_hi;
      logic par;
      logic in_slab;
   } side_type;

   // Front stage: plane minus origin, magnitudes and signs, parallel test.
   logic signed [W:0] org_w;
   logic signed [W:0] dir_w;
   logic signed [W:0] thr_w;
   logic signed [W:0] n_hi;
   logic signed [W:0] n_hi_neg;
   logic signed [W:0] n_lo;
   logic signed [W:0] n_lo_neg;
   logic [W-1:0]      mag_hi;
   logic [W-1:0]      mag_lo;
   logic [W-1:0]      mag_dir;
   side_type          side_in;

   assign org_w    = {origin[W-1], origin};
   assign dir_w    = {direction[W-1], direction};
   assign thr_w    = (W+1)'(threshold);
   assign n_hi     = ONE - org_w;
   assign n_hi_neg = org_w - ONE;
   assign n_lo     = -ONE - org_w;
   assign n_lo_neg = org_w + ONE;
   assign mag_hi   = n_hi[W] ? n_hi_neg[W-1:0] : n_hi[W-1:0];
   assign mag_lo   = n_lo[W] ? n_lo_neg[W-1:0] : n_lo[W-1:0];
   assign mag_dir  = direction[W-1] ? (W'(0) - direction) : direction;

   always_comb begin
      side_in.neg_hi  = n_hi[W] ^ direction[W-1];
      side_in.neg_lo  = n_lo[W] ^ direction[W-1];
      side_in.par     = (direction == '0) || ((dir_w < thr_w) && (dir_w > -thr_w));
      side_in.in_slab = (org_w >= -ONE) && (org_w <= ONE);
   end

   logic [W-1:0] num_hi_ff;
   logic [W-1:0] num_lo_ff;
   logic [W-1:0] den_ff;
   side_type     side_ff [0:rbox_pkg::DIV_LAT];

   always_ff @(posedge clock) begin
      if (en) begin
         num_hi_ff  <= mag_hi;
         num_lo_ff  <= mag_lo;
         den_ff     <= mag_dir;
         side_ff[0] <= side_in;
         for (int i = 0; i < rbox_pkg::DIV_LAT; i++) begin
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   logic [W-1:0] quo_lo;
   logic [W-1:0] quo_hi;
   logic         ovf_lo;
   logic         ovf_hi;

   rbox_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_lo (
      .clock   (clock),
      .en      (en),
      .num_mag (num_lo_ff),
      .den     (den_ff),
      .quo     (quo_lo),
      .ovf     (ovf_lo)
   );

   rbox_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_hi (
      .clock   (clock),
      .en      (en),
      .num_mag (num_hi_ff),
      .den     (den_ff),
      .quo     (quo_hi),
      .ovf     (ovf_hi)
   );

   // Applies the sign and clamps to the signed 32-bit range.
   function automatic logic [W-1:0] sat_quo(input logic [W-1:0] q, input logic over,
                                            input logic neg);
      logic [W-1:0] res;
      if (!neg) begin
         res = (over || q[W-1]) ? rbox_pkg::SAT_HI : q;
      end else begin
         res = (over || (q[W-1] && |q[W-2:0])) ? rbox_pkg::SAT_LO : (W'(0) - q);
      end
      return res;
   endfunction

   side_type           side_out;
   logic signed [W-1:0] t_lo;
   logic signed [W-1:0] t_hi;
   rbox_pkg::slab_type slab_in;
   rbox_pkg::slab_type slab_ff;

   assign side_out = side_ff[rbox_pkg::DIV_LAT];
   assign t_lo     = sat_quo(quo_lo, ovf_lo, side_out.neg_lo);
   assign t_hi     = sat_quo(quo_hi, ovf_hi, side_out.neg_hi);

   always_comb begin
      slab_in.miss = side_out.par && !side_out.in_slab;
      if (side_out.par) begin
         slab_in.enter = rbox_pkg::SAT_LO;
         slab_in.leave = rbox_pkg::SAT_HI;
      end else if (t_lo > t_hi) begin
         slab_in.enter = t_hi;
         slab_in.leave = t_lo;
      end else begin
         slab_in.enter = t_lo;
         slab_in.leave = t_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slab_ff <= slab_in;
      end
   end

   assign slab = slab_ff;

endmodule

// ===== rtl/core/ray_unit_box_slab_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// Ray versus unit box intersection unit
// Slab test of an object-space ray against the box [-1,1] on all three axes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction carries
//   req_chan  in         origin_x/y/z, direction_x/y/z, signed fixed point
//   rsp_chan  out        hit, t_near, t_far, signed fixed point
//   csr_*     in         parallel_threshold write (no read-back)
//
// One ray is accepted per cycle while the skid register is empty. Most of the
// path from acceptance to the result being presented lies in the bit-serial
// pipelined dividers (one quotient bit per stage, 32 stages plus setup).
// Reset is synchronous; it clears the valid bits of the pipeline, output and
// skid registers and sets the threshold back to its reset value of 7.
// A stalled result first fills a skid register, after which the whole
// pipeline holds; nothing is dropped or repeated.
//
module ray_unit_box_slab_intersection_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [rbox_pkg::THR_W-1:0]   csr_wdata,
   rbox_req_if.sink                     req_chan,
   rbox_rsp_if.source                   rsp_chan
);

   localparam int W = rbox_pkg::DATA_W;

   // Parallel threshold register.
   logic [rbox_pkg::THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rbox_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // The pipeline advances as long as the skid register is empty. This enable
   // comes straight from a flop, so ready does not depend on the sink.
   logic skid_vld_ff;
   logic en;
   logic accept;

   assign en             = !skid_vld_ff;
   assign req_chan.ready = en;
   assign accept         = req_chan.valid && en;

   // Valid bits travel alongside the data through every stage.
   logic vld_ff [0:rbox_pkg::PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rbox_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= accept;
         for (int i = 1; i < rbox_pkg::PIPE_LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   rbox_pkg::slab_type slab_x;
   rbox_pkg::slab_type slab_y;
   rbox_pkg::slab_type slab_z;

   rbox_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_x (
      .clock     (clock),
      .en        (en),
      .origin    (req_chan.origin_x),
      .direction (req_chan.direction_x),
      .threshold (thr_ff),
      .slab      (slab_x)
   );

   rbox_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_y (
      .clock     (clock),
      .en        (en),
      .origin    (req_chan.origin_y),
      .direction (req_chan.direction_y),
      .threshold (thr_ff),
      .slab      (slab_y)
   );

   rbox_axis #(.FRACTION_BITS(FRACTION_BITS)) u_axis_z (
      .clock     (clock),
      .en        (en),
      .origin    (req_chan.origin_z),
      .direction (req_chan.direction_z),
      .threshold (thr_ff),
      .slab      (slab_z)
   );

   // Near distance is the greatest entry, far distance the least exit.
   logic signed [W-1:0] near_xy;
   logic signed [W-1:0] far_xy;
   logic signed [W-1:0] near_in;
   logic signed [W-1:0] far_in;
   logic signed [W-1:0] near_ff;
   logic signed [W-1:0] far_ff;
   logic                miss_ff;

   always_comb begin
      near_xy = ($signed(slab_x.enter) > $signed(slab_y.enter)) ? slab_x.enter : slab_y.enter;
      far_xy  = ($signed(slab_x.leave) < $signed(slab_y.leave)) ? slab_x.leave : slab_y.leave;
      near_in = ($signed(slab_z.enter) > near_xy) ? $signed(slab_z.enter) : near_xy;
      far_in  = ($signed(slab_z.leave) < far_xy) ? $signed(slab_z.leave) : far_xy;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         miss_ff <= slab_x.miss || slab_y.miss || slab_z.miss;
      end
   end

   // Final decision; a miss reports both distances as zero.
   logic                res_hit;
   logic signed [W-1:0] res_near;
   logic signed [W-1:0] res_far;

   assign res_hit  = !miss_ff && !(near_ff > far_ff);
   assign res_near = res_hit ? near_ff : '0;
   assign res_far  = res_hit ? far_ff : '0;

   // Output register with one skid entry behind it.
   logic                out_vld_ff;
   logic                out_hit_ff;
   logic signed [W-1:0] out_near_ff;
   logic signed [W-1:0] out_far_ff;
   logic                skid_hit_ff;
   logic signed [W-1:0] skid_near_ff;
   logic signed [W-1:0] skid_far_ff;
   logic                last_vld;

   assign last_vld = vld_ff[rbox_pkg::PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_chan.ready) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_chan.ready) begin
         out_vld_ff <= last_vld;
      end else if (last_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_chan.ready) begin
            out_hit_ff  <= skid_hit_ff;
            out_near_ff <= skid_near_ff;
            out_far_ff  <= skid_far_ff;
         end
      end else if (!out_vld_ff || rsp_chan.ready) begin
         out_hit_ff  <= res_hit;
         out_near_ff <= res_near;
         out_far_ff  <= res_far;
      end else begin
         skid_hit_ff  <= res_hit;
         skid_near_ff <= res_near;
         skid_far_ff  <= res_far;
      end
   end

   assign rsp_chan.valid  = out_vld_ff;
   assign rsp_chan.hit    = out_hit_ff;
   assign rsp_chan.t_near = out_near_ff;
   assign rsp_chan.t_far  = out_far_ff;

endmodule
